// File: hdl/gcrp_pkg.sv
// ----------------------------------------------------------------------------
// gcrp_pkg: shared types and constants of the glyph cell range packer
// Field widths, slot masks, the event/result payloads and the request
// bundle that drives one range insert.
// ----------------------------------------------------------------------------
package gcrp_pkg;

    localparam int IDX_W  = 16;               // point index width
    localparam int RUN_W  = IDX_W + 1;        // run end may reach 2^IDX_W
    localparam int WRAP_W = 15;               // held wrap length
    localparam int WORD_W = 32;               // packed cell word

    localparam logic [WORD_W-1:0] SLOT1_MASK = 32'h0000_0003;
    localparam logic [WORD_W-1:0] SLOT2_MASK = 32'h0000_001C;
    localparam logic [WORD_W-1:0] SLOT3_MASK = 32'h0000_00E0;

    localparam logic [7:0] HALF_LIMIT = 8'd255;  // halved index must stay below
    localparam logic [7:0] SLOT1_LEN_MAX = 8'd3;
    localparam logic [7:0] SLOT_LEN_MAX  = 8'd7;

    localparam logic EVT_CURVE  = 1'b0;
    localparam logic EVT_FINISH = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] segment_start;
        logic [IDX_W-1:0] contour_begin;
        logic [IDX_W-1:0] contour_end;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] cell_word_out;
        logic              ok;
        logic [WRAP_W-1:0] start_length_closed;
    } out_item_t;

    typedef struct packed {
        logic             en;
        logic             from_ok;
        logic [IDX_W-1:0] from_idx;
        logic [RUN_W-1:0] to_idx;
    } pack_req_t;

endpackage

// File: hdl/gcrp_in_if.sv
// ----------------------------------------------------------------------------
// gcrp_in_if: event channel
// Valid/ready channel that carries one curve or contour-end event.
// ----------------------------------------------------------------------------
interface gcrp_in_if;
    import gcrp_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [IDX_W-1:0] segment_start;
    logic [IDX_W-1:0] contour_begin;
    logic [IDX_W-1:0] contour_end;

    modport source (
        output valid, kind, segment_start, contour_begin, contour_end,
        input  ready
    );

    modport sink (
        input  valid, kind, segment_start, contour_begin, contour_end,
        output ready
    );
endinterface

// File: hdl/gcrp_out_if.sv
// ----------------------------------------------------------------------------
// gcrp_out_if: result channel
// Valid/ready channel that carries the packed cell word after one event.
// ----------------------------------------------------------------------------
interface gcrp_out_if;
    import gcrp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] cell_word_out;
    logic              ok;
    logic [WRAP_W-1:0] start_length_closed;

    modport source (
        output valid, cell_word_out, ok, start_length_closed,
        input  ready
    );

    modport sink (
        input  valid, cell_word_out, ok, start_length_closed,
        output ready
    );
endinterface

// File: hdl/gcrp_pack.sv
// ----------------------------------------------------------------------------
// gcrp_pack: single range insert
// Halves both ends, checks limits and ORs the range into the first slot
// that fits; any failure clears the word.
// ----------------------------------------------------------------------------
module gcrp_pack
    import gcrp_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  pack_req_t         req,
    output logic [WORD_W-1:0] word_out,
    output logic              ok
);
    logic [IDX_W-2:0] from_half;
    logic [RUN_W-2:0] to_half;
    logic             bad;
    logic             ordered;
    logic [7:0]       len;
    logic             fits1;
    logic             fits;
    logic [WORD_W-1:0] slot1_bits;
    logic [WORD_W-1:0] slot2_bits;
    logic [WORD_W-1:0] slot3_bits;

    assign from_half = req.from_idx[IDX_W-1:1];
    assign to_half   = req.to_idx[RUN_W-1:1];

    assign bad = !req.from_ok
              || (from_half >= (IDX_W-1)'(HALF_LIMIT))
              || (to_half >= (RUN_W-1)'(HALF_LIMIT));

    // both halves are below 255 here, so an 8-bit difference is exact
    assign ordered = to_half[7:0] >= from_half[7:0];
    assign len     = to_half[7:0] - from_half[7:0];
    assign fits1   = ordered && (len <= SLOT1_LEN_MAX);
    assign fits    = ordered && (len <= SLOT_LEN_MAX);

    assign slot1_bits = {16'h0, from_half[7:0], 6'b0, len[1:0]};
    assign slot2_bits = {8'h0, from_half[7:0], 11'b0, len[2:0], 2'b0};
    assign slot3_bits = {from_half[7:0], 16'h0, len[2:0], 5'b0};

    always_comb
    begin
        if (!req.en)
            word_out = word;
        else if (bad)
            word_out = '0;
        else if (fits1 && ((word & SLOT1_MASK) == '0))
            word_out = word | slot1_bits;
        else if (!fits)
            word_out = '0;
        else if ((word & SLOT2_MASK) == '0)
            word_out = word | slot2_bits;
        else if ((word & SLOT3_MASK) == '0)
            word_out = word | slot3_bits;
        else
            word_out = '0;
    end

    assign ok = !req.en || (word_out != '0);
endmodule

// File: hdl/gcrp_core.sv
// ----------------------------------------------------------------------------
// gcrp_core: run tracking and cell word state
// Holds the open run, wrap length and cell word; computes the result of
// one event and commits the new state on step.
// ----------------------------------------------------------------------------
module gcrp_core
    import gcrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);
    logic [WORD_W-1:0] cell_word_reg,      cell_word_next;
    logic [IDX_W-1:0]  run_from_reg,       run_from_next;
    logic              run_from_valid_reg, run_from_valid_next;
    logic [RUN_W-1:0]  run_to_reg,         run_to_next;
    logic              run_to_valid_reg,   run_to_valid_next;
    logic [WRAP_W-1:0] wrap_length_reg,    wrap_length_next;

    pack_req_t         req_a;
    pack_req_t         req_b;
    logic [WORD_W-1:0] word_a;
    logic              ok_a;
    logic              ok_b;
    logic [WRAP_W-1:0] closed;

    logic [RUN_W-1:0]  seg_ext;
    logic [RUN_W-1:0]  cend_ext;
    logic [RUN_W-1:0]  cbeg_ext;
    logic [RUN_W-1:0]  wrap_span;
    logic [RUN_W-1:0]  run_span;
    logic              close_run;
    logic              to_wrap;
    logic              tail_run;
    logic              wrap_nz;

    assign seg_ext   = {1'b0, item.segment_start};
    assign cend_ext  = {1'b0, item.contour_end};
    assign cbeg_ext  = {1'b0, item.contour_begin};
    assign wrap_span = {1'b0, wrap_length_reg, 1'b0};
    assign run_span  = run_to_reg - {1'b0, run_from_reg};

    assign close_run = run_to_valid_reg && (run_to_reg != seg_ext);
    assign to_wrap   = run_from_valid_reg && (run_from_reg == item.contour_begin);
    assign tail_run  = run_to_valid_reg && (run_to_reg < cend_ext);
    assign wrap_nz   = wrap_length_reg != '0;

    always_comb
    begin
        req_a               = '0;
        req_b               = '0;
        closed              = '0;
        run_from_next       = run_from_reg;
        run_from_valid_next = run_from_valid_reg;
        run_to_next         = run_to_reg;
        run_to_valid_next   = run_to_valid_reg;
        wrap_length_next    = wrap_length_reg;

        if (item.kind == EVT_CURVE)
        begin
            if (close_run && to_wrap)
                wrap_length_next = run_span[WRAP_W:1];
            req_a = '{en: close_run && !to_wrap, from_ok: run_from_valid_reg,
                      from_idx: run_from_reg, to_idx: run_to_reg};
            if (close_run || !run_from_valid_reg)
                run_from_next = item.segment_start;
            run_from_valid_next = 1'b1;
            run_to_next         = seg_ext + RUN_W'(2);
            run_to_valid_next   = 1'b1;
        end
        else
        begin
            // flush the open run, else close against the contour end
            if (tail_run)
                req_a = '{en: 1'b1, from_ok: run_from_valid_reg,
                          from_idx: run_from_reg, to_idx: run_to_reg};
            else if (run_from_valid_reg && wrap_nz)
            begin
                req_a  = '{en: 1'b1, from_ok: 1'b1, from_idx: run_from_reg,
                           to_idx: cend_ext + wrap_span};
                closed = wrap_length_reg;
            end
            else if (run_from_valid_reg)
                req_a = '{en: 1'b1, from_ok: 1'b1, from_idx: run_from_reg,
                          to_idx: cend_ext};

            // a wrap run never joined goes in from the contour begin
            req_b = '{en: wrap_nz && (tail_run || !run_from_valid_reg), from_ok: 1'b1,
                      from_idx: item.contour_begin, to_idx: cbeg_ext + wrap_span};

            run_from_next       = '0;
            run_from_valid_next = 1'b0;
            run_to_next         = '0;
            run_to_valid_next   = 1'b0;
            wrap_length_next    = '0;
        end
    end

    gcrp_pack u_pack_a (
        .word     (cell_word_reg),
        .req      (req_a),
        .word_out (word_a),
        .ok       (ok_a)
    );

    gcrp_pack u_pack_b (
        .word     (word_a),
        .req      (req_b),
        .word_out (cell_word_next),
        .ok       (ok_b)
    );

    assign result = '{cell_word_out: cell_word_next, ok: ok_a && ok_b,
                      start_length_closed: closed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_word_reg      <= '0;
            run_from_reg       <= '0;
            run_from_valid_reg <= 1'b0;
            run_to_reg         <= '0;
            run_to_valid_reg   <= 1'b0;
            wrap_length_reg    <= '0;
        end
        else if (step)
        begin
            cell_word_reg      <= cell_word_next;
            run_from_reg       <= run_from_next;
            run_from_valid_reg <= run_from_valid_next;
            run_to_reg         <= run_to_next;
            run_to_valid_reg   <= run_to_valid_next;
            wrap_length_reg    <= wrap_length_next;
        end
    end

    // a contour end leaves no open run and no pending wrap
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.kind == EVT_FINISH) |=>
            !run_to_valid_reg && !run_from_valid_reg && (wrap_length_reg == '0))
        else $error("contour end left run state behind");

    // a curve always leaves a complete open run
    a_curve_opens: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.kind == EVT_CURVE) |=> run_from_valid_reg && run_to_valid_reg)
        else $error("curve did not open a run");

    // only a contour end can report a joined wrap length
    a_closed_curve: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.kind == EVT_CURVE) |-> result.start_length_closed == '0)
        else $error("wrap length reported on a curve event");

    // the committed word is the one reported
    a_word_commit: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> cell_word_reg == $past(result.cell_word_out))
        else $error("cell word differs from reported result");
endmodule

// File: hdl/glyph_cell_range_packer_top.sv
// ----------------------------------------------------------------------------
// glyph_cell_range_packer_top: per-cell curve range packer
// Input register, event core and result register on valid/ready channels.
// ----------------------------------------------------------------------------
// Feed curve events (kind 0) and contour-end events (kind 1) for one grid
// cell on evt; every event yields exactly one result on res with the packed
// cell word after it, an ok flag and any wrap length joined at contour end.
// The block takes one event per clock cycle when res is drained. An event
// passes through the input register and then the result register before
// its result is valid on res. The run/cell-word state update is
// combinational between the two registers, including both chained range
// inserts of a contour end. A stalled result holds in the result register
// while the input register can still take one more event if it is empty.
// ----------------------------------------------------------------------------
module glyph_cell_range_packer_top
    import gcrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    gcrp_in_if.sink  evt,
    gcrp_out_if.source res
);
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      advance;
    logic      step;
    out_item_t core_result;

    // advance the pipe when the result slot is empty or being taken
    assign advance   = !out_valid_reg || res.ready;
    assign step      = in_valid_reg && advance;
    assign evt.ready = !in_valid_reg || advance;

    // input register: hold the event until the core consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (evt.ready)
            in_valid_reg <= evt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
            in_item_reg <= '{kind: evt.kind, segment_start: evt.segment_start,
                             contour_begin: evt.contour_begin,
                             contour_end: evt.contour_end};
    end

    gcrp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (core_result)
    );

    // result register: load on a step, drop the valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= core_result;
    end

    assign res.valid               = out_valid_reg;
    assign res.cell_word_out       = out_item_reg.cell_word_out;
    assign res.ok                  = out_item_reg.ok;
    assign res.start_length_closed = out_item_reg.start_length_closed;
endmodule
